### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same check with the antecedent and consequent split out.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

### rtl/qdsw_pkg.sv
// ----------------------------------------------------------------------------
// qdsw_pkg
// Shared widths, codes, stage types and helpers for the quadrature decoder.
// ----------------------------------------------------------------------------
package qdsw_pkg;

    localparam int COUNT_WIDTH = 32;   // edge counter width, 8..32
    localparam int POS_WIDTH   = 32;
    localparam int SCALE_WIDTH = 32;
    localparam int OUT_WIDTH   = 48;
    localparam int TICK_WIDTH  = 16;
    localparam int PROD_WIDTH  = COUNT_WIDTH + SCALE_WIDTH;
    localparam int WIDE_WIDTH  = 64;
    localparam int IDX_WIDTH   = 2;

    // item kinds
    localparam logic [1:0] OP_PIN   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // register indexes
    localparam logic [IDX_WIDTH-1:0] REG_WINDOW_MS      = 2'd0;
    localparam logic [IDX_WIDTH-1:0] REG_SPEED_SCALE    = 2'd1;
    localparam logic [IDX_WIDTH-1:0] REG_DISTANCE_SCALE = 2'd2;

    // transition codes {prev A, prev B, A, B}
    localparam logic [3:0] TR_UP_11_01 = 4'b1101;
    localparam logic [3:0] TR_UP_01_00 = 4'b0100;
    localparam logic [3:0] TR_UP_00_10 = 4'b0010;
    localparam logic [3:0] TR_UP_10_11 = 4'b1011;
    localparam logic [3:0] TR_DN_11_10 = 4'b1110;
    localparam logic [3:0] TR_DN_01_11 = 4'b0111;
    localparam logic [3:0] TR_DN_00_01 = 4'b0001;
    localparam logic [3:0] TR_DN_10_00 = 4'b1000;

    localparam logic [WIDE_WIDTH-1:0] LIM_NEG = WIDE_WIDTH'(1) << (OUT_WIDTH - 1);
    localparam logic [WIDE_WIDTH-1:0] LIM_POS = LIM_NEG - WIDE_WIDTH'(1);

    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] pos;
        logic signed [COUNT_WIDTH-1:0] delta;
        logic                          upd;
    } dec_t;

    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] pos;
        logic                          dist_neg;
        logic [PROD_WIDTH-1:0]         dist_mag;
        logic                          speed_neg;
        logic [PROD_WIDTH-1:0]         speed_mag;
        logic                          upd;
    } prod_t;

    typedef struct packed {
        logic [POS_WIDTH-1:0] position;
        logic [OUT_WIDTH-1:0] distance;
        logic [OUT_WIDTH-1:0] speed;
        logic                 upd;
    } res_t;

    // absolute value; the most negative count maps to its unsigned magnitude
    function automatic logic [COUNT_WIDTH-1:0] magnitude(
        input logic signed [COUNT_WIDTH-1:0] v
    );
        return v[COUNT_WIDTH-1] ? (-v) : v;
    endfunction

    // signed result from sign and magnitude, clamped to OUT_WIDTH bits
    function automatic logic [OUT_WIDTH-1:0] sat_out(
        input logic                  neg,
        input logic [PROD_WIDTH-1:0] mag
    );
        logic [WIDE_WIDTH-1:0] m;
        logic [WIDE_WIDTH-1:0] p;
        logic [OUT_WIDTH-1:0]  r;
        m = WIDE_WIDTH'(mag);
        if (neg) begin
            p = (m > LIM_NEG) ? LIM_NEG : m;
            r = p[OUT_WIDTH-1:0];
            return -r;
        end
        p = (m > LIM_POS) ? LIM_POS : m;
        return p[OUT_WIDTH-1:0];
    endfunction

endpackage

### rtl/qdsw_decode.sv
// ----------------------------------------------------------------------------
// qdsw_decode
// Transition decode, edge counter, window timer; stage register to multiply.
// ----------------------------------------------------------------------------
module qdsw_decode (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         op,
    input  logic                               pin_a,
    input  logic                               pin_b,
    input  logic [qdsw_pkg::TICK_WIDTH-1:0]    window_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output qdsw_pkg::dec_t                     out_data
);

    logic [1:0]                          prev_pins_reg, prev_pins_next;
    logic [qdsw_pkg::COUNT_WIDTH-1:0]    edge_count_reg, edge_count_next;
    logic [qdsw_pkg::COUNT_WIDTH-1:0]    win_start_reg, win_start_next;
    logic [qdsw_pkg::TICK_WIDTH-1:0]     elapsed_reg, elapsed_next;
    logic [qdsw_pkg::TICK_WIDTH-1:0]     tick_inc;
    logic [3:0]                          code;
    logic                                upd;
    logic                                valid_reg;
    qdsw_pkg::dec_t                      data_reg;
    logic                                accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign code     = {prev_pins_reg, pin_a, pin_b};
    assign tick_inc = elapsed_reg + 1'b1;

    always_comb begin
        prev_pins_next  = prev_pins_reg;
        edge_count_next = edge_count_reg;
        win_start_next  = win_start_reg;
        elapsed_next    = elapsed_reg;
        upd             = 1'b0;
        unique case (op)
            qdsw_pkg::OP_PIN: begin
                prev_pins_next = {pin_a, pin_b};
                case (code) inside
                    qdsw_pkg::TR_UP_11_01, qdsw_pkg::TR_UP_01_00,
                    qdsw_pkg::TR_UP_00_10, qdsw_pkg::TR_UP_10_11: begin
                        edge_count_next = edge_count_reg + 1'b1;
                    end
                    qdsw_pkg::TR_DN_11_10, qdsw_pkg::TR_DN_01_11,
                    qdsw_pkg::TR_DN_00_01, qdsw_pkg::TR_DN_10_00: begin
                        edge_count_next = edge_count_reg - 1'b1;
                    end
                    default: begin
                        edge_count_next = edge_count_reg;
                    end
                endcase
            end
            qdsw_pkg::OP_TICK: begin
                // a zero window behaves like one: every tick closes it
                if (tick_inc >= window_ms) begin
                    win_start_next = edge_count_reg;
                    elapsed_next   = '0;
                    upd            = 1'b1;
                end else begin
                    elapsed_next = tick_inc;
                end
            end
            qdsw_pkg::OP_CLEAR: begin
                edge_count_next = '0;   // window start kept on purpose
            end
            default: begin
                upd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pins_reg  <= '0;
            edge_count_reg <= '0;
            win_start_reg  <= '0;
            elapsed_reg    <= '0;
            valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                prev_pins_reg  <= prev_pins_next;
                edge_count_reg <= edge_count_next;
                win_start_reg  <= win_start_next;
                elapsed_reg    <= elapsed_next;
            end
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg.pos   <= edge_count_next;
            data_reg.delta <= edge_count_reg - win_start_reg;
            data_reg.upd   <= upd;
        end
    end

endmodule

### rtl/qdsw_mul.sv
// ----------------------------------------------------------------------------
// qdsw_mul
// Magnitude times scale for distance and speed; registered products.
// ----------------------------------------------------------------------------
module qdsw_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  qdsw_pkg::dec_t                     in_data,
    input  logic [qdsw_pkg::SCALE_WIDTH-1:0]   speed_scale,
    input  logic [qdsw_pkg::SCALE_WIDTH-1:0]   distance_scale,
    output logic                               out_valid,
    input  logic                               out_ready,
    output qdsw_pkg::prod_t                    out_data
);

    logic [qdsw_pkg::COUNT_WIDTH-1:0] pos_mag;
    logic [qdsw_pkg::COUNT_WIDTH-1:0] delta_mag;
    logic [qdsw_pkg::PROD_WIDTH-1:0]  dist_prod;
    logic [qdsw_pkg::PROD_WIDTH-1:0]  speed_prod;
    logic                             valid_reg;
    qdsw_pkg::prod_t                  data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign pos_mag    = qdsw_pkg::magnitude(in_data.pos);
    assign delta_mag  = qdsw_pkg::magnitude(in_data.delta);
    assign dist_prod  = qdsw_pkg::PROD_WIDTH'(pos_mag) *
                        qdsw_pkg::PROD_WIDTH'(distance_scale);
    assign speed_prod = qdsw_pkg::PROD_WIDTH'(delta_mag) *
                        qdsw_pkg::PROD_WIDTH'(speed_scale);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg.pos       <= in_data.pos;
            data_reg.dist_neg  <= in_data.pos[qdsw_pkg::COUNT_WIDTH-1];
            data_reg.dist_mag  <= dist_prod;
            data_reg.speed_neg <= in_data.delta[qdsw_pkg::COUNT_WIDTH-1];
            data_reg.speed_mag <= speed_prod;
            data_reg.upd       <= in_data.upd;
        end
    end

endmodule

### rtl/qdsw_sat.sv
// ----------------------------------------------------------------------------
// qdsw_sat
// Sign restore and 48-bit clamp; output register that also holds the speed.
// ----------------------------------------------------------------------------
module qdsw_sat (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  qdsw_pkg::prod_t     in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output qdsw_pkg::res_t      out_data
);

    logic                                 valid_reg;
    logic [qdsw_pkg::OUT_WIDTH-1:0]       speed_reg;
    logic [qdsw_pkg::POS_WIDTH-1:0]       position_reg;
    logic [qdsw_pkg::OUT_WIDTH-1:0]       distance_reg;
    logic                                 upd_reg;
    logic                                 load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign out_valid         = valid_reg;
    assign out_data.position = position_reg;
    assign out_data.distance = distance_reg;
    assign out_data.speed    = speed_reg;
    assign out_data.upd      = upd_reg;

    // speed_reg is the held speed state; only a closing tick replaces it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            speed_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load && in_data.upd) begin
                speed_reg <= qdsw_pkg::sat_out(in_data.speed_neg, in_data.speed_mag);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            position_reg <= qdsw_pkg::POS_WIDTH'(in_data.pos);
            distance_reg <= qdsw_pkg::sat_out(in_data.dist_neg, in_data.dist_mag);
            upd_reg      <= in_data.upd;
        end
    end

endmodule

### rtl/quadrature_decoder_speed_window.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_speed_window
// x4 quadrature decoder with position, scaled distance and windowed speed.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transfer per item. s_tuser = op (pin sample, ms tick,
//   position clear), s_tdata holds the A/B pin levels for pin samples.
//   m_ channel: one result transfer per input transfer, in order, carrying
//   position, distance (position * distance_scale) and the last window speed;
//   m_tuser flags the tick that closed a window.
//   cfg_ channel: register writes (window_ms, speed_scale, distance_scale),
//   always ready; write only while no items are in flight.
// Pipeline: three registered stages between input transfer and m_tvalid
//   (decode, multiply, clamp/output register). Throughput: one item per cycle
//   while m_tready is high, with all three stages busy at once.
// Reset (aresetn low, synchronous): counters, window state and speed clear,
//   registers return to 50 ms / 1.0 / 1.0 and the pipeline empties.
// Stall: when m_tready is low, the result holds in the output register and
//   the stages behind it keep filling until each holds an item; s_tready only
//   drops once the whole pipeline is full.
// ----------------------------------------------------------------------------
module quadrature_decoder_speed_window (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [0] pin_a, [1] pin_b, [7:2] zero
    input  logic [1:0]   s_tuser,   // [1:0] op
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [31:0] position, [79:32] distance,
                                    // [127:80] speed
    output logic [0:0]   m_tuser,   // [0] speed_updated
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [qdsw_pkg::TICK_WIDTH-1:0]  window_ms_reg;
    logic [qdsw_pkg::SCALE_WIDTH-1:0] speed_scale_reg;
    logic [qdsw_pkg::SCALE_WIDTH-1:0] distance_scale_reg;

    logic             dec_valid, dec_ready;
    qdsw_pkg::dec_t   dec_data;
    logic             mul_valid, mul_ready;
    qdsw_pkg::prod_t  mul_data;
    qdsw_pkg::res_t   res_data;

    // configuration: writes always accepted, unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ms_reg      <= 16'd50;
            speed_scale_reg    <= 32'd65536;
            distance_scale_reg <= 32'd65536;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                qdsw_pkg::REG_WINDOW_MS: begin
                    window_ms_reg <= cfg_data[qdsw_pkg::TICK_WIDTH-1:0];
                end
                qdsw_pkg::REG_SPEED_SCALE: begin
                    speed_scale_reg <= cfg_data;
                end
                qdsw_pkg::REG_DISTANCE_SCALE: begin
                    distance_scale_reg <= cfg_data;
                end
                default: begin
                    window_ms_reg <= window_ms_reg;
                end
            endcase
        end
    end

    // stage 1: transition decode and window bookkeeping
    qdsw_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (s_tuser),
        .pin_a     (s_tdata[0]),
        .pin_b     (s_tdata[1]),
        .window_ms (window_ms_reg),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    // stage 2: the two 32x32 products
    qdsw_mul u_mul (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (dec_valid),
        .in_ready       (dec_ready),
        .in_data        (dec_data),
        .speed_scale    (speed_scale_reg),
        .distance_scale (distance_scale_reg),
        .out_valid      (mul_valid),
        .out_ready      (mul_ready),
        .out_data       (mul_data)
    );

    // stage 3: clamp and output register
    qdsw_sat u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_data   (mul_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata    = {res_data.speed, res_data.distance, res_data.position};
    assign m_tuser[0] = res_data.upd;

endmodule

### rtl/qdsw_checker.sv
// ----------------------------------------------------------------------------
// qdsw_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qdsw_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [0:0]   m_tuser
);

    `ASSERT_IMPLY(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, ##1 m_tvalid, "result dropped while stalled")
    `ASSERT_IMPLY(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, ##1 $stable(m_tdata), "result changed while stalled")
    `ASSERT_CLK(a_speed_kept, aclk, aresetn, (m_tvalid && m_tready) ##1 (m_tvalid && !m_tuser[0]) |-> (m_tdata[127:80] == $past(m_tdata[127:80])), "speed changed without a window close")
    `ASSERT_IMPLY(a_zero_dist, aclk, aresetn, m_tvalid && (m_tdata[31:0] == 32'd0), m_tdata[79:32] == 48'd0, "nonzero distance at zero position")

endmodule

bind quadrature_decoder_speed_window qdsw_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### test/quadrature_decoder_speed_window_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadrature_decoder_speed_window_test
// Self-checking bench for the x4 quadrature decoder. Pin samples, ms ticks,
// position clears and unused codes go in through the s_ stream. An in-bench
// decoder model predicts position, distance, speed and the window flag for
// every transfer, and each m_ transfer is checked against the oldest
// prediction. Phases cover several register settings and idle patterns and
// a long receiver hold-off.
// ----------------------------------------------------------------------------
module quadrature_decoder_speed_window_test;

    localparam logic [1:0]  OP_UNUSED = 2'd3;      // no defined action
    localparam int          LATENCY   = 3;
    localparam int          HOLD_LEN  = 300;       // receiver hold-off, cycles
    localparam int unsigned MAX_CYC   = 2_000_000;
    localparam int          MAX_PRINT = 40;

    typedef struct packed {
        logic [1:0] op;
        logic       pin_a;
        logic       pin_b;
    } enc_item_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    quadrature_decoder_speed_window u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // stimulus and expectation stores
    enc_item_t       pend_q[$];
    qdsw_pkg::res_t  readout_q[$];

    int          src_pct = 0;     // chance in 100 that the sender idles
    int          sink_pct = 0;    // chance in 100 that the receiver stalls
    bit          pressure_on = 1'b0;
    int          mismatches = 0;
    int unsigned cyc_count = 0;

    // decoder model: registers and state
    logic [qdsw_pkg::TICK_WIDTH-1:0]         win_ms = 16'd50;
    logic [qdsw_pkg::SCALE_WIDTH-1:0]        spd_scale = 32'd65536;
    logic [qdsw_pkg::SCALE_WIDTH-1:0]        dist_scale = 32'd65536;
    logic [1:0]                              prev_ab = '0;
    logic signed [qdsw_pkg::COUNT_WIDTH-1:0] edge_cnt = '0;
    logic signed [qdsw_pkg::COUNT_WIDTH-1:0] win_start = '0;
    logic [qdsw_pkg::TICK_WIDTH-1:0]         ticks = '0;
    logic [qdsw_pkg::OUT_WIDTH-1:0]          speed_val = '0;

    // stimulus-side pin levels, {A, B}
    logic [1:0] gen_ab = '0;

    // signed count times unsigned Q16.16 factor, clamped to 48-bit signed
    function automatic logic [qdsw_pkg::OUT_WIDTH-1:0] clamp_product(
        input logic signed [qdsw_pkg::COUNT_WIDTH-1:0] cnt,
        input logic [qdsw_pkg::SCALE_WIDTH-1:0]        factor
    );
        logic signed [63:0] wide;
        logic [63:0]        mag;
        logic [63:0]        prod;
        wide = cnt;
        mag  = (wide < 0) ? 64'(-wide) : 64'(wide);
        prod = mag * 64'(factor);
        if (wide < 0) begin
            if (prod > (64'd1 << 47))
                prod = 64'd1 << 47;
            prod = -prod;
            return prod[qdsw_pkg::OUT_WIDTH-1:0];
        end
        if (prod > ((64'd1 << 47) - 64'd1))
            prod = (64'd1 << 47) - 64'd1;
        return prod[qdsw_pkg::OUT_WIDTH-1:0];
    endfunction

    // advance the model by one item and return the result it must produce
    function automatic qdsw_pkg::res_t decode_item(input enc_item_t it);
        qdsw_pkg::res_t                          r;
        logic [1:0]                              now;
        logic [3:0]                              tr;
        logic signed [qdsw_pkg::COUNT_WIDTH-1:0] delta;
        r.upd = 1'b0;
        case (it.op)
            qdsw_pkg::OP_PIN: begin
                now = {it.pin_a, it.pin_b};
                tr  = {prev_ab, now};
                case (tr)
                    qdsw_pkg::TR_UP_11_01, qdsw_pkg::TR_UP_01_00,
                    qdsw_pkg::TR_UP_00_10, qdsw_pkg::TR_UP_10_11:
                        edge_cnt = edge_cnt + 1;
                    qdsw_pkg::TR_DN_11_10, qdsw_pkg::TR_DN_01_11,
                    qdsw_pkg::TR_DN_00_01, qdsw_pkg::TR_DN_10_00:
                        edge_cnt = edge_cnt - 1;
                    default: ;  // no change or illegal double change
                endcase
                prev_ab = now;
            end
            qdsw_pkg::OP_TICK: begin
                ticks = ticks + 1'b1;
                // a zero window compares like one: every tick closes
                if (ticks >= win_ms) begin
                    delta     = edge_cnt - win_start;
                    speed_val = clamp_product(delta, spd_scale);
                    win_start = edge_cnt;
                    ticks     = '0;
                    r.upd     = 1'b1;
                end
            end
            qdsw_pkg::OP_CLEAR: edge_cnt = '0;   // window start and ticks kept
            default: ;
        endcase
        r.position = edge_cnt;
        r.distance = clamp_product(edge_cnt, dist_scale);
        r.speed    = speed_val;
        return r;
    endfunction

    function automatic void check_field(
        input string       fname,
        input logic [63:0] exp_v,
        input logic [63:0] got_v
    );
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= MAX_PRINT)
                $display("%0t: %s mismatch, expected %h, got %h",
                         $time, fname, exp_v, got_v);
        end
    endfunction

    // ------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count >= MAX_CYC) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sender: unless it randomly idles, loads the next pending item whenever the slot is free
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        enc_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= src_pct) begin
                it = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, it.pin_b, it.pin_a};
                s_tuser  <= it.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict from what actually crossed the input channel
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            readout_q.push_back(decode_item({s_tuser, s_tdata[0], s_tdata[1]}));
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        if (pressure_on && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        qdsw_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (readout_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_PRINT)
                    $display("%0t: unexpected result, expected none, got %h / %h",
                             $time, m_tdata, m_tuser);
            end else begin
                want = readout_q.pop_front();
                check_field("position", 64'(want.position), 64'(m_tdata[31:0]));
                check_field("distance", 64'(want.distance), 64'(m_tdata[79:32]));
                check_field("speed", 64'(want.speed), 64'(m_tdata[127:80]));
                check_field("speed_updated", 64'(want.upd), 64'(m_tuser[0]));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_pins(input logic [1:0] ab);
        pend_q.push_back({qdsw_pkg::OP_PIN, ab});
        gen_ab = ab;
    endtask

    task automatic push_op(input logic [1:0] op);
        pend_q.push_back({op, 2'($urandom_range(3))});
    endtask

    // one legal quadrature step: up 00-10-11-01-00, down the reverse
    task automatic push_step(input bit up);
        if (up)
            push_pins({~gen_ab[0], gen_ab[1]});
        else
            push_pins({gen_ab[0], ~gen_ab[1]});
    endtask

    // mostly clean encoder motion in runs, with ticks, clears and noise mixed in
    task automatic random_motion(input int n);
        bit dir;
        int r;
        dir = $urandom_range(1);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 66) begin
                if ($urandom_range(15) == 0)
                    dir = ~dir;
                push_step(dir);
            end else if (r < 78) begin
                push_op(qdsw_pkg::OP_TICK);
            end else if (r < 81) begin
                push_op(qdsw_pkg::OP_CLEAR);
            end else if (r < 85) begin
                push_op(OP_UNUSED);
            end else if (r < 92) begin
                push_pins(gen_ab);            // repeated sample
            end else begin
                push_pins(~gen_ab);           // illegal double change
            end
        end
    endtask

    // wait until every item has gone through and the pipeline is empty
    task automatic settle();
        while (pend_q.size() != 0 || s_tvalid || readout_q.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            qdsw_pkg::REG_WINDOW_MS:      win_ms = val[qdsw_pkg::TICK_WIDTH-1:0];
            qdsw_pkg::REG_SPEED_SCALE:    spd_scale = val;
            qdsw_pkg::REG_DISTANCE_SCALE: dist_scale = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] w, input logic [31:0] s,
                            input logic [31:0] d);
        write_reg(qdsw_pkg::REG_WINDOW_MS, w);
        write_reg(qdsw_pkg::REG_SPEED_SCALE, s);
        write_reg(qdsw_pkg::REG_DISTANCE_SCALE, d);
    endtask

    task automatic run_phase(input int src, input int sink, input int n);
        src_pct  = src;
        sink_pct = sink;
        random_motion(n);
        settle();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [1:0] walk[16];
        walk = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
                 2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset registers: walk through all 16 transition codes
        // (pins start at 00), then tick, clear and the unused code
        foreach (walk[i])
            push_pins(walk[i]);
        push_op(qdsw_pkg::OP_TICK);
        push_op(OP_UNUSED);
        push_step(1'b1);
        push_op(qdsw_pkg::OP_CLEAR);
        push_op(qdsw_pkg::OP_TICK);
        push_step(1'b0);
        push_op(OP_UNUSED);
        settle();

        // zero window, largest factors, no idling
        set_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(0, 0, 150);

        // zero factors, sender idling
        set_regs(32'd3, 32'd0, 32'd0);
        run_phase(55, 0, 150);

        // one-tick window, random factors, receiver stalling
        set_regs(32'd1, $urandom, $urandom);
        run_phase(0, 55, 150);

        // both sides idling
        set_regs(32'd2, $urandom, $urandom);
        run_phase(24, 24, 150);

        // long receiver hold-off while the sender keeps offering
        set_regs(32'd4, 32'd65536, 32'h8000_0000);
        src_pct  = 0;
        sink_pct = 0;
        random_motion(100);
        pressure_on = 1'b1;
        settle();

        // widest window, back to random motion
        set_regs(32'd65535, $urandom, $urandom);
        run_phase(24, 24, 80);

        repeat (4 * LATENCY) @(posedge aclk);
        if (mismatches == 0 && readout_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
